// ===== rtl/fsk_pkg.sv =====
// shared types and constants for the binary fsk modulator
// no dependencies; imported by every module of the block but fsk_ram
package fsk_pkg;

  localparam int unsigned PhaseW      = 32;
  localparam int unsigned RunW        = 7;
  localparam int unsigned AmpW        = 15;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned SymbolW     = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned CordicW     = 33;

  localparam logic [SymbolW-1:0] SymOne      = 8'd1;
  localparam logic [SymbolW-1:0] SymZero     = 8'd0;
  localparam logic [SymbolW-1:0] SymOneChar  = 8'd49;
  localparam logic [SymbolW-1:0] SymZeroChar = 8'd48;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegStepOne  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStepZero = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRunOne   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRunZero  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAmp      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOffRe    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegOffIm    = 3'd6;

  // cordic start vector, gain-compensated, q2.30
  localparam logic signed [CordicW-1:0] CordicGain = 33'sh026DD3B6A;

  // arctangent of 2^-i in units of a 2^32 turn
  localparam logic [31:0] AtanTurn [CordicSteps] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct packed {
    logic [PhaseW-1:0] step_one;
    logic [PhaseW-1:0] step_zero;
    logic [RunW-1:0]   run_one;
    logic [RunW-1:0]   run_zero;
  } tone_cfg_t;

  // per-sample tag travelling alongside the datapath
  typedef struct packed {
    logic vld;
    logic last;
    logic bad;
  } smp_tag_t;

  // round q2.30 product back to integer, add offset, clamp to 16 bits
  function automatic logic [SampleW-1:0] scale_sat(input logic signed [47:0] prod,
                                                   input logic signed [15:0] offs);
    logic signed [48:0] sum;
    logic signed [19:0] val;
    sum = {prod[47], prod} + 49'sd536870912;
    val = $signed({sum[48], sum[48:30]}) + $signed({{4{offs[15]}}, offs});
    if (val > 20'sd32767) begin
      scale_sat = 16'h7FFF;
    end else if (val < -20'sd32768) begin
      scale_sat = 16'h8000;
    end else begin
      scale_sat = val[15:0];
    end
  endfunction

endpackage

// ===== rtl/fsk_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module fsk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fsk_ctrl.sv =====
// symbol sequencer: decodes the symbol, runs the phase read-modify-write
// against the phase ram and issues one sample per cycle while ce_i is high; uses fsk_pkg
module fsk_ctrl import fsk_pkg::*; #(
  parameter int unsigned MAX_RUN = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ce_i,
  input  tone_cfg_t          cfg_i,
  input  logic               in_valid_i,
  input  logic [SymbolW-1:0] in_symbol_i,
  output logic               in_ready_o,
  output logic               ram_re_o,
  input  logic [PhaseW-1:0]  ram_rdata_i,
  output logic               ram_we_o,
  output logic [PhaseW-1:0]  ram_wdata_o,
  output smp_tag_t           issue_tag_o,
  output logic [PhaseW-1:0]  issue_phase_o
);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  localparam logic [RunW-1:0] MaxRun = RunW'(MAX_RUN);

  state_e            state_q, state_d;
  logic [RunW-1:0]   cnt_q, cnt_d;
  logic [RunW-1:0]   run_q, run_d;
  logic [PhaseW-1:0] step_q, step_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              first_q, first_d;
  logic              written_q, written_d;

  logic              accept;
  logic              is_one, is_zero;
  logic [RunW-1:0]   run_raw, run_eff;
  logic [PhaseW-1:0] phase_cur, phase_nxt;

  assign is_one  = (in_symbol_i == SymOne) || (in_symbol_i == SymOneChar);
  assign is_zero = (in_symbol_i == SymZero) || (in_symbol_i == SymZeroChar);
  assign run_raw = is_one ? cfg_i.run_one : cfg_i.run_zero;
  assign run_eff = (run_raw > MaxRun) ? MaxRun : run_raw;

  assign in_ready_o = (state_q == StIdle) && ce_i;
  assign accept     = in_ready_o && in_valid_i;

  // the ram holds no phase until the first write: read it as zero till then
  assign phase_cur = first_q ? (written_q ? ram_rdata_i : '0) : phase_q;
  assign phase_nxt = phase_cur + step_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    run_d         = run_q;
    step_d        = step_q;
    phase_d       = phase_q;
    first_d       = first_q;
    written_d     = written_q;
    ram_re_o      = 1'b0;
    ram_we_o      = 1'b0;
    ram_wdata_o   = phase_nxt;
    issue_tag_o   = '0;
    issue_phase_o = phase_cur;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (!is_one && !is_zero) begin
            issue_tag_o.vld = 1'b1;
            issue_tag_o.bad = 1'b1;
          end else if (run_eff != '0) begin
            state_d  = StRun;
            run_d    = run_eff;
            step_d   = is_one ? cfg_i.step_one : cfg_i.step_zero;
            cnt_d    = RunW'(1);
            first_d  = 1'b1;
            ram_re_o = 1'b1;
          end
        end
      end
      StRun: begin
        if (ce_i) begin
          issue_tag_o.vld  = 1'b1;
          issue_tag_o.last = (cnt_q == run_q);
          ram_we_o         = 1'b1;
          written_d        = 1'b1;
          phase_d          = phase_nxt;
          first_d          = 1'b0;
          cnt_d            = cnt_q + RunW'(1);
          if (cnt_q == run_q) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      run_q     <= '0;
      first_q   <= 1'b0;
      written_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      run_q     <= run_d;
      first_q   <= first_d;
      written_q <= written_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    phase_q <= phase_d;
  end

endmodule

// ===== rtl/fsk_cordic.sv =====
// pipelined rotation cordic, one stage per iteration, plus quadrant fold
// uses fsk_pkg for the gain, arctangent table and sample tag
module fsk_cordic import fsk_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      ce_i,
  input  smp_tag_t                  tag_i,
  input  logic [PhaseW-1:0]         phase_i,
  output smp_tag_t                  tag_o,
  output logic signed [PhaseW-1:0]  cos_o,
  output logic signed [PhaseW-1:0]  sin_o
);

  localparam logic [PhaseW-1:0] KeepMask =
    ~((PhaseW'(1) << (PhaseW - TABLE_ADDR_BITS)) - PhaseW'(1));

  logic signed [CordicW-1:0] x_q [CordicSteps+1];
  logic signed [CordicW-1:0] y_q [CordicSteps+1];
  logic signed [CordicW-1:0] z_q [CordicSteps];
  logic [1:0]                quad_q [CordicSteps+1];
  smp_tag_t                  tag_q [CordicSteps+1];

  logic [PhaseW-1:0] phase_trunc;

  assign phase_trunc = phase_i & KeepMask;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      x_q[0]    <= CordicGain;
      y_q[0]    <= '0;
      z_q[0]    <= $signed({3'b000, phase_trunc[29:0]});
      quad_q[0] <= phase_trunc[31:30];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else if (ce_i) begin
      tag_q[0] <= tag_i;
    end
  end

  for (genvar k = 0; k < CordicSteps; k++) begin : g_stage
    logic signed [CordicW-1:0] dx, dy;
    assign dx = y_q[k] >>> k;
    assign dy = x_q[k] >>> k;

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        if (!z_q[k][CordicW-1]) begin
          x_q[k+1] <= x_q[k] - dx;
          y_q[k+1] <= y_q[k] + dy;
        end else begin
          x_q[k+1] <= x_q[k] + dx;
          y_q[k+1] <= y_q[k] - dy;
        end
        quad_q[k+1] <= quad_q[k];
      end
    end

    // the angle residue after the last stage steers nothing
    if (k + 1 < CordicSteps) begin : g_angle
      logic signed [CordicW-1:0] da;
      assign da = $signed({1'b0, AtanTurn[k]});

      always_ff @(posedge clk_i) begin
        if (ce_i) begin
          if (!z_q[k][CordicW-1]) begin
            z_q[k+1] <= z_q[k] - da;
          end else begin
            z_q[k+1] <= z_q[k] + da;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k+1] <= '0;
      end else if (ce_i) begin
        tag_q[k+1] <= tag_q[k];
      end
    end
  end

  logic signed [CordicW-1:0] xe, ye, nx, ny;
  assign xe = x_q[CordicSteps];
  assign ye = y_q[CordicSteps];
  assign nx = -xe;
  assign ny = -ye;

  always_comb begin
    unique case (quad_q[CordicSteps])
      2'd0: begin
        cos_o = xe[PhaseW-1:0];
        sin_o = ye[PhaseW-1:0];
      end
      2'd1: begin
        cos_o = ny[PhaseW-1:0];
        sin_o = xe[PhaseW-1:0];
      end
      2'd2: begin
        cos_o = nx[PhaseW-1:0];
        sin_o = ny[PhaseW-1:0];
      end
      default: begin
        cos_o = ye[PhaseW-1:0];
        sin_o = nx[PhaseW-1:0];
      end
    endcase
  end

  assign tag_o = tag_q[CordicSteps];

endmodule

// ===== rtl/fsk_scale.sv =====
// gain multiply, rounding, offset and saturation, then the output register
// uses fsk_pkg for scale_sat and the sample tag
module fsk_scale import fsk_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      ce_i,
  input  smp_tag_t                  tag_i,
  input  logic signed [PhaseW-1:0]  cos_i,
  input  logic signed [PhaseW-1:0]  sin_i,
  input  logic [AmpW-1:0]           amp_i,
  input  logic signed [SampleW-1:0] off_re_i,
  input  logic signed [SampleW-1:0] off_im_i,
  output logic                      valid_o,
  output logic [SampleW-1:0]        re_o,
  output logic [SampleW-1:0]        im_o,
  output logic                      last_o,
  output logic                      bad_o
);

  logic signed [47:0] prod_c, prod_s;
  logic signed [47:0] prod_c_q, prod_s_q;
  smp_tag_t           tag_q;
  logic               valid_q, last_q, bad_q;
  logic [SampleW-1:0] re_q, im_q;

  assign prod_c = $signed({1'b0, amp_i}) * cos_i;
  assign prod_s = $signed({1'b0, amp_i}) * sin_i;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      prod_c_q <= prod_c;
      prod_s_q <= prod_s;
      // a bad symbol carries zero samples
      re_q     <= tag_q.bad ? '0 : scale_sat(prod_c_q, off_re_i);
      im_q     <= tag_q.bad ? '0 : scale_sat(prod_s_q, off_im_i);
      last_q   <= tag_q.last;
      bad_q    <= tag_q.bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= '0;
      valid_q <= 1'b0;
    end else if (ce_i) begin
      tag_q   <= tag_i;
      valid_q <= tag_q.vld;
    end
  end

  assign valid_o = valid_q;
  assign re_o    = re_q;
  assign im_o    = im_q;
  assign last_o  = last_q;
  assign bad_o   = bad_q;

endmodule

// ===== rtl/binary_fsk_nco_modulator.sv =====
// channel  | direction | payload
// s_axis   | in        | tdata[7:0] symbol_byte
// m_axis   | out       | tdata[15:0] in_phase, [31:16] quadrature; tlast; tuser bad_symbol
// cfg      | in        | cfg_idx_i register index, cfg_data_i value, cfg_we_i strobe
//
// a valid symbol of run length n holds the input while it is accepted and the
// phase ram read, then for its n samples, one a cycle unless m_axis stalls, as the
// phase is read, advanced and written back. a bad symbol gives one bad sample.
// samples then pass the cordic, multiply and output registers to m_axis.
// a stall on m_axis freezes the whole sample pipeline. reset clears control
// state; the phase reads as zero until first written, so no clearing pass.
// top level: continuous-phase binary fsk modulator; uses fsk_pkg, fsk_ram,
// fsk_ctrl, fsk_cordic and fsk_scale
module binary_fsk_nco_modulator import fsk_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned MAX_RUN         = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] symbol_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // [15:0] in_phase, [31:16] quadrature
  output logic                m_axis_tlast,
  output logic                m_axis_tuser,   // [0] bad_symbol
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  tone_cfg_t                 tone_q;
  logic [AmpW-1:0]           amp_q;
  logic signed [SampleW-1:0] off_re_q, off_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_q.step_one  <= '0;
      tone_q.step_zero <= '0;
      tone_q.run_one   <= RunW'(1);
      tone_q.run_zero  <= RunW'(1);
      amp_q            <= '0;
      off_re_q         <= '0;
      off_im_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStepOne:  tone_q.step_one  <= cfg_data_i;
        RegStepZero: tone_q.step_zero <= cfg_data_i;
        RegRunOne:   tone_q.run_one   <= cfg_data_i[RunW-1:0];
        RegRunZero:  tone_q.run_zero  <= cfg_data_i[RunW-1:0];
        RegAmp:      amp_q            <= cfg_data_i[AmpW-1:0];
        RegOffRe:    off_re_q         <= $signed(cfg_data_i[SampleW-1:0]);
        RegOffIm:    off_im_q         <= $signed(cfg_data_i[SampleW-1:0]);
        default: ;
      endcase
    end
  end

  logic                     ce;
  logic                     ram_re, ram_we;
  logic [PhaseW-1:0]        ram_rdata, ram_wdata;
  smp_tag_t                 issue_tag, cordic_tag;
  logic [PhaseW-1:0]        issue_phase;
  logic signed [PhaseW-1:0] cos_v, sin_v;
  logic [SampleW-1:0]       re_v, im_v;

  // pipeline moves whenever the output register is free or being taken
  assign ce = !m_axis_tvalid || m_axis_tready;

  fsk_ram #(
    .WIDTH (PhaseW),
    .DEPTH (1)
  ) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (1'b0),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (1'b0),
    .rdata_o (ram_rdata)
  );

  fsk_ctrl #(
    .MAX_RUN (MAX_RUN)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ce_i          (ce),
    .cfg_i         (tone_q),
    .in_valid_i    (s_axis_tvalid),
    .in_symbol_i   (s_axis_tdata),
    .in_ready_o    (s_axis_tready),
    .ram_re_o      (ram_re),
    .ram_rdata_i   (ram_rdata),
    .ram_we_o      (ram_we),
    .ram_wdata_o   (ram_wdata),
    .issue_tag_o   (issue_tag),
    .issue_phase_o (issue_phase)
  );

  fsk_cordic #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .tag_i   (issue_tag),
    .phase_i (issue_phase),
    .tag_o   (cordic_tag),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  fsk_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ce_i     (ce),
    .tag_i    (cordic_tag),
    .cos_i    (cos_v),
    .sin_i    (sin_v),
    .amp_i    (amp_q),
    .off_re_i (off_re_q),
    .off_im_i (off_im_q),
    .valid_o  (m_axis_tvalid),
    .re_o     (re_v),
    .im_o     (im_v),
    .last_o   (m_axis_tlast),
    .bad_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {im_v, re_v};

endmodule
